// ----- src/flash_doubleword_write_combiner_defines.svh -----
// assertion macros for the flash double-word write combiner
// taken in by the module that checks its own logic; no other dependencies
`ifndef FLASH_DOUBLEWORD_WRITE_COMBINER_DEFINES_SVH
`define FLASH_DOUBLEWORD_WRITE_COMBINER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FDWC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("fdwc assertion failed");
// next-cycle implication
`define FDWC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("fdwc assertion failed");
`else
`define FDWC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FDWC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/fdwc_pkg.sv -----
// shared types, constants and the flash address helper of the write combiner
// no dependencies
`timescale 1ns / 1ps

package fdwc_pkg;

	localparam int unsigned ADDR_W  = 24;
	localparam int unsigned FADDR_W = 25;
	localparam int unsigned WORD_W  = 32;

	localparam logic [WORD_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;
	localparam logic [ADDR_W-1:0] OFFSET_RESET = 24'h80_0000;
	localparam logic [ADDR_W-1:0] PREV_RESET   = 24'h00_0004;
	localparam logic [ADDR_W-1:0] HIGH_STEP    = 24'h00_0004;

	localparam logic CMD_WORD     = 1'b0;
	localparam logic CMD_FLUSH    = 1'b1;
	localparam logic KIND_PROGRAM = 1'b0;
	localparam logic KIND_LOCK    = 1'b1;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] raw_address;
		logic [WORD_W-1:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic               kind;
		logic [FADDR_W-1:0] write_address;
		logic [WORD_W-1:0]  low_word;
		logic [WORD_W-1:0]  high_word;
		logic               last;
	} result_t;

	// results of one item plus the state update it asks for
	typedef struct packed {
		result_t    r0;
		result_t    r1;
		logic [1:0] count;
		logic       upd_addr;
		logic       upd_word;
	} pair_out_t;

	// raw plus offset, low three bits cleared
	function automatic logic [FADDR_W-1:0] flash_addr(
		input logic [ADDR_W-1:0] raw,
		input logic [ADDR_W-1:0] offset
	);
		logic [FADDR_W-1:0] sum;
		sum = {1'b0, raw} + {1'b0, offset[ADDR_W-1:3], 3'b000};
		return {sum[FADDR_W-1:3], 3'b000};
	endfunction

endpackage

// ----- src/fdwc_pair_logic.sv -----
// combinational pairing of one word or flush against the held previous address
// depends on fdwc_pkg
`timescale 1ns / 1ps

module fdwc_pair_logic (
	input  fdwc_pkg::in_item_t  item,
	input  logic [23:0]         prev_addr,
	input  logic [31:0]         pend_word,
	input  logic [23:0]         offset,
	output fdwc_pkg::pair_out_t res
);
	import fdwc_pkg::*;

	logic               prev_low;
	logic               raw_low;
	logic               partner;
	logic [FADDR_W-1:0] pend_faddr;
	logic [FADDR_W-1:0] raw_faddr;
	result_t            padded_pend;
	result_t            lock_res;
	result_t            new_high;
	result_t            full_pair;

	assign prev_low   = (prev_addr[2:0] == 3'b000);
	assign raw_low    = (item.raw_address[2:0] == 3'b000);
	assign partner    = prev_low && (item.raw_address == prev_addr + HIGH_STEP);
	assign pend_faddr = flash_addr(prev_addr, offset);
	assign raw_faddr  = flash_addr(item.raw_address, offset);

	always_comb begin
		padded_pend = '{kind: KIND_PROGRAM, write_address: pend_faddr,
			low_word: pend_word, high_word: ALL_ONES, last: 1'b0};
		lock_res    = '{kind: KIND_LOCK, write_address: '0,
			low_word: '0, high_word: '0, last: 1'b0};
		new_high    = '{kind: KIND_PROGRAM, write_address: raw_faddr,
			low_word: ALL_ONES, high_word: item.data_word, last: 1'b0};
		full_pair   = '{kind: KIND_PROGRAM, write_address: pend_faddr,
			low_word: pend_word, high_word: item.data_word, last: 1'b0};

		res = '0;
		case (item.command)
			CMD_FLUSH: begin
				// flush leaves state alone
				if (prev_low) begin
					res.r0    = padded_pend;
					res.r1    = lock_res;
					res.count = 2'd2;
				end else begin
					res.r0    = lock_res;
					res.count = 2'd1;
				end
			end
			CMD_WORD: begin
				res.upd_addr = 1'b1;
				if (raw_low) begin
					res.upd_word = 1'b1;
					if (prev_low) begin
						res.r0    = padded_pend;
						res.count = 2'd1;
					end
				end else if (partner) begin
					res.r0    = full_pair;
					res.count = 2'd1;
				end else if (prev_low) begin
					res.r0    = padded_pend;
					res.r1    = new_high;
					res.count = 2'd2;
				end else begin
					res.r0    = new_high;
					res.count = 2'd1;
				end
			end
			default: res = '0;
		endcase
		res.r0.last = (res.count == 2'd1);
		res.r1.last = (res.count == 2'd2);
	end

endmodule

// ----- src/fdwc_result_buf.sv -----
// two-slot result register that hands out the results of one item in order
// depends on fdwc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "flash_doubleword_write_combiner_defines.svh"

module fdwc_result_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  fdwc_pkg::result_t r0,
	input  fdwc_pkg::result_t r1,
	input  logic [1:0]        count,
	output logic              out_valid,
	input  logic              out_ready,
	output fdwc_pkg::result_t out_res
);
	import fdwc_pkg::*;

	logic [1:0] cnt_q;
	result_t    slot0_q;
	result_t    slot1_q;
	logic       take;
	logic       load;

	assign out_valid  = (cnt_q != 2'd0);
	assign out_res    = slot0_q;
	assign take       = out_valid && out_ready;
	// the buffer is free once its final result leaves
	assign load_ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign load       = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= count;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (take) begin
			slot0_q <= slot1_q;
		end
	end

	`FDWC_ASSERT_IMPL(a_two_head_not_last, clk, arst_n, cnt_q == 2'd2, !slot0_q.last)
	`FDWC_ASSERT_IMPL(a_one_head_last, clk, arst_n, cnt_q == 2'd1, slot0_q.last)
	`FDWC_ASSERT_NEXT(a_load_count, clk, arst_n, load && (count != 2'd0), cnt_q == $past(count))

endmodule

// ----- src/flash_doubleword_write_combiner.sv -----
// channel   | dir | payload
// s_axis    | in  | tuser: command; tdata: raw_address[23:0], data_word[55:24]
// m_axis    | out | tuser: kind; tlast: last; tdata: write_address, low_word, high_word
// cfg       | in  | address_offset write, 24 bits
//
// an item is held in the input register, is paired against the held
// state and moves into the two-slot result register; items giving zero or one
// result flow at one per cycle while m_axis takes each result, items giving two
// hold the next item until their second result leaves the single result port.
// reset (arst_n, async) clears the control state, offset to 0x800000 and the
// previous address to 4. a stalled m_axis holds the input register and then tready.
// depends on fdwc_pkg, fdwc_pair_logic, fdwc_result_buf
`timescale 1ns / 1ps

module flash_doubleword_write_combiner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // raw_address[23:0], data_word[55:24]
	input  logic        s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // write_address[24:0], low_word[56:25],
	                                    // high_word[88:57], zero fill
	output logic        m_axis_tuser,   // kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);
	import fdwc_pkg::*;

	in_item_t          item_s1;
	logic              valid_s1;
	logic [ADDR_W-1:0] offset_q;
	logic [ADDR_W-1:0] prev_addr_q;
	logic [WORD_W-1:0] pend_word_q;
	pair_out_t         pair;
	logic              buf_ready;
	logic              advance;
	result_t           head;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && buf_ready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			offset_q    <= OFFSET_RESET;
			prev_addr_q <= PREV_RESET;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (cfg_valid) begin
				offset_q <= cfg_data;
			end
			if (advance && pair.upd_addr) begin
				prev_addr_q <= item_s1.raw_address;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= '{command: s_axis_tuser, raw_address: s_axis_tdata[23:0],
				data_word: s_axis_tdata[55:24]};
		end
		if (advance && pair.upd_word) begin
			pend_word_q <= item_s1.data_word;
		end
	end

	fdwc_pair_logic u_pair (
		.item      (item_s1),
		.prev_addr (prev_addr_q),
		.pend_word (pend_word_q),
		.offset    (offset_q),
		.res       (pair)
	);

	fdwc_result_buf u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (buf_ready),
		.r0         (pair.r0),
		.r1         (pair.r1),
		.count      (pair.count),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (head)
	);

	assign m_axis_tdata = {7'b0, head.high_word, head.low_word, head.write_address};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

// ----- sim/tb_flash_doubleword_write_combiner.sv -----
// testbench for flash_doubleword_write_combiner: opening table, then random word streams
// under several address offsets, each result checked against listed ops or a local pairing predictor
// depends on fdwc_pkg and the combiner rtl
`timescale 1ns / 1ps

module tb_flash_doubleword_write_combiner;
	import fdwc_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS   = 170;

	// one stimulus row; when typed is set the listed program ops are taken as given
	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] raw_address;
		logic [WORD_W-1:0] data_word;
		logic              typed;
		logic [1:0]        op_count;
		result_t           op0;
		result_t           op1;
	} plan_row_t;

	localparam result_t NO_OP   = '0;
	localparam result_t LOCK_OP = '{KIND_LOCK, 25'd0, 32'd0, 32'd0, 1'b0};

	localparam plan_row_t OPENING_ROWS [23] = '{
		// lock only right after reset, no half pair held
		'{CMD_FLUSH, 24'h00_0000, 32'h0000_0000, 1'b1, 2'd1,
			'{KIND_LOCK, 25'd0, 32'd0, 32'd0, 1'b1}, NO_OP},
		'{CMD_WORD, 24'h00_0000, 32'h0000_0000, 1'b1, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0004, 32'hFFFF_FFFF, 1'b1, 2'd1,
			'{KIND_PROGRAM, 25'h080_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1}, NO_OP},
		'{CMD_WORD, 24'hFF_FFF8, 32'hA5A5_A5A5, 1'b1, 2'd0, NO_OP, NO_OP},
		// flush ignores its data and keeps the held half pair
		'{CMD_FLUSH, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1, 2'd2,
			'{KIND_PROGRAM, 25'h17F_FFF8, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b0},
			'{KIND_LOCK, 25'd0, 32'd0, 32'd0, 1'b1}},
		'{CMD_FLUSH, 24'h12_3456, 32'h0000_0000, 1'b1, 2'd2,
			'{KIND_PROGRAM, 25'h17F_FFF8, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b0},
			'{KIND_LOCK, 25'd0, 32'd0, 32'd0, 1'b1}},
		'{CMD_WORD, 24'hFF_FFFC, 32'h5A5A_5A5A, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0003, 32'h1234_5678, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0010, 32'h0BAD_F00D, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0018, 32'h1357_9BDF, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0025, 32'h2468_ACE0, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0030, 32'hCAFE_F00D, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0037, 32'h89AB_CDEF, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0040, 32'h0123_4567, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0044, 32'hFEDC_BA98, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_FLUSH, 24'h00_0044, 32'hDEAD_BEEF, 1'b0, 2'd0, NO_OP, NO_OP},
		// top of the address range, unaligned, carries into bit 24
		'{CMD_WORD, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1, 2'd1,
			'{KIND_PROGRAM, 25'h17F_FFF8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, NO_OP},
		'{CMD_WORD, 24'h00_0008, 32'h0000_0001, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_000C, 32'h8000_0000, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0000, 32'h7FFF_FFFF, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_000D, 32'h5555_5555, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_WORD, 24'h00_0008, 32'hAAAA_AAAA, 1'b0, 2'd0, NO_OP, NO_OP},
		'{CMD_FLUSH, 24'h00_0000, 32'h0000_0000, 1'b0, 2'd0, NO_OP, NO_OP}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;   // raw_address[23:0], data_word[55:24]
	logic        s_axis_tuser = 1'b0; // command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;        // write_address[24:0], low_word[56:25],
	                                  // high_word[88:57], zero fill
	logic        m_axis_tuser;        // kind
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cfg_data = '0;

	// predictor state
	logic [ADDR_W-1:0] offset_reg = OFFSET_RESET;
	logic [ADDR_W-1:0] last_raw = PREV_RESET;
	logic [WORD_W-1:0] held_low_word = '0;

	result_t           due_ops [$];
	int                mismatch_count = 0;
	int                items_sent = 0;
	bit                no_idle = 1'b0;
	logic [ADDR_W-1:0] seq_base = '0;

	flash_doubleword_write_combiner i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// 8-aligned flash address; the offset's three low bits never count
	function automatic logic [FADDR_W-1:0] pair_base(input logic [ADDR_W-1:0] raw);
		return ({1'b0, raw} + {1'b0, offset_reg & 24'hFF_FFF8}) & ~25'h7;
	endfunction

	function automatic result_t program_op(input logic [FADDR_W-1:0] addr,
		input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
		return '{KIND_PROGRAM, addr, lo, hi, 1'b0};
	endfunction

	function automatic plan_row_t word_row(input logic cmd, input logic [ADDR_W-1:0] raw,
		input logic [WORD_W-1:0] word);
		return '{cmd, raw, word, 1'b0, 2'd0, NO_OP, NO_OP};
	endfunction

	// works out the program ops of one item and advances the pairing state
	function automatic plan_row_t plan_flash_ops(input plan_row_t row);
		plan_row_t p;
		logic      held;
		p = row;
		p.op0 = NO_OP;
		p.op1 = NO_OP;
		p.op_count = 2'd0;
		held = (last_raw[2:0] == 3'b000);
		if (row.command == CMD_FLUSH) begin
			if (held) begin
				p.op0 = program_op(pair_base(last_raw), held_low_word, ALL_ONES);
				p.op1 = LOCK_OP;
				p.op_count = 2'd2;
			end else begin
				p.op0 = LOCK_OP;
				p.op_count = 2'd1;
			end
		end else if (row.raw_address[2:0] == 3'b000) begin
			if (held) begin
				p.op0 = program_op(pair_base(last_raw), held_low_word, ALL_ONES);
				p.op_count = 2'd1;
			end
			held_low_word = row.data_word;
			last_raw = row.raw_address;
		end else begin
			if (held && {1'b0, row.raw_address} == {1'b0, last_raw} + 25'd4) begin
				p.op0 = program_op(pair_base(last_raw), held_low_word, row.data_word);
				p.op_count = 2'd1;
			end else if (held) begin
				p.op0 = program_op(pair_base(last_raw), held_low_word, ALL_ONES);
				p.op1 = program_op(pair_base(row.raw_address), ALL_ONES, row.data_word);
				p.op_count = 2'd2;
			end else begin
				p.op0 = program_op(pair_base(row.raw_address), ALL_ONES, row.data_word);
				p.op_count = 2'd1;
			end
			last_raw = row.raw_address;
		end
		if (p.op_count == 2'd2)
			p.op1.last = 1'b1;
		else if (p.op_count == 2'd1)
			p.op0.last = 1'b1;
		return p;
	endfunction

	task automatic send_item(input plan_row_t row);
		int        gap;
		plan_row_t planned;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= row.command;
		s_axis_tdata  <= {row.data_word, row.raw_address};
		do @(posedge clk); while (!s_axis_tready);
		planned = plan_flash_ops(row);
		if (row.typed)
			planned = row;
		if (planned.op_count != 2'd0)
			due_ops.push_back(planned.op0);
		if (planned.op_count == 2'd2)
			due_ops.push_back(planned.op1);
		items_sent++;
	endtask

	task automatic write_offset(input logic [ADDR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		offset_reg = value;
	endtask

	// wait for every due op, then let items with no op leave the pipeline
	task automatic drain_results();
		int waited;
		waited = 0;
		while (due_ops.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_ops.size() != 0) begin
			$error("%0d program ops never arrived", due_ops.size());
			mismatch_count += due_ops.size();
			due_ops.delete();
		end
	endtask

	task automatic run_random_phase(input int count);
		int                stop_at;
		int                pick;
		logic [31:0]       draw;
		logic [ADDR_W-1:0] base;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 29) == 0)
				no_idle = !no_idle;
			draw = $urandom;
			if (draw[31:30] == 2'b00)
				base = {draw[23:3], 3'b000};
			else
				base = seq_base;
			seq_base = base + 24'd8;
			pick = $urandom_range(0, 99);
			draw = $urandom;
			if (pick < 45) begin
				send_item(word_row(CMD_WORD, base, $urandom));
				send_item(word_row(CMD_WORD, base + 24'd4, $urandom));
			end else if (pick < 52) begin
				// a flush in between keeps the low half waiting for its partner
				send_item(word_row(CMD_WORD, base, $urandom));
				send_item(word_row(CMD_FLUSH, draw[23:0], $urandom));
				send_item(word_row(CMD_WORD, base + 24'd4, $urandom));
			end else if (pick < 64) begin
				send_item(word_row(CMD_WORD, base, $urandom));
			end else if (pick < 72) begin
				send_item(word_row(CMD_WORD, base + 24'd4, $urandom));
			end else if (pick < 82) begin
				send_item(word_row(CMD_WORD, draw[23:0], $urandom));
			end else if (pick < 90) begin
				send_item(word_row(CMD_FLUSH, draw[23:0], $urandom));
			end else begin
				send_item(word_row(draw[31], draw[23:0], $urandom));
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin : result_ready
		int stall;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_axis_tvalid));
		end
	end

	always @(posedge clk) begin : result_check
		result_t seen;
		result_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = '{m_axis_tuser, m_axis_tdata[24:0], m_axis_tdata[56:25],
				m_axis_tdata[88:57], m_axis_tlast};
			if (due_ops.size() == 0) begin
				$error("program op with none due: kind %0b addr %h", seen.kind,
					seen.write_address);
				mismatch_count++;
			end else begin
				due = due_ops.pop_front();
				if (seen.kind !== due.kind) begin
					$error("kind: expected %0b, got %0b", due.kind, seen.kind);
					mismatch_count++;
				end
				if (seen.write_address !== due.write_address) begin
					$error("write_address: expected %h, got %h", due.write_address,
						seen.write_address);
					mismatch_count++;
				end
				if (seen.low_word !== due.low_word) begin
					$error("low_word: expected %h, got %h", due.low_word, seen.low_word);
					mismatch_count++;
				end
				if (seen.high_word !== due.high_word) begin
					$error("high_word: expected %h, got %h", due.high_word, seen.high_word);
					mismatch_count++;
				end
				if (seen.last !== due.last) begin
					$error("last: expected %0b, got %0b", due.last, seen.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [31:0] draw;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (OPENING_ROWS[i])
			send_item(OPENING_ROWS[i]);
		s_axis_tvalid <= 1'b0;
		drain_results();
		for (int phase = 0; phase < 5; phase++) begin
			draw = $urandom;
			case (phase)
				0: write_offset(24'h00_0000);
				1: write_offset(24'hFF_FFF8);
				2: write_offset({draw[23:3], 3'b000});
				// low offset bits may be set here, the block drops them
				3: write_offset(draw[23:0]);
				default: write_offset(OFFSET_RESET);
			endcase
			run_random_phase(PHASE_ITEMS);
			drain_results();
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : run_limit
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/fdwc_pkg.sv
src/fdwc_pair_logic.sv
src/fdwc_result_buf.sv
src/flash_doubleword_write_combiner.sv
sim/tb_flash_doubleword_write_combiner.sv
